### src/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int LKV_ENTRIES = 16;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int DATA_W = 32;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic upd;
        logic shift;
        logic load;
        logic valid;
    } cell_ctl_t;

endpackage

`default_nettype wire

### src/lkv_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      capture,
    input  wire [lkv_pkg::DATA_W-1:0] lookup_key,
    input  lkv_pkg::cell_ctl_t       ctl,
    input  wire [lkv_pkg::DATA_W-1:0] new_key,
    input  wire [lkv_pkg::DATA_W-1:0] new_value,
    input  wire [lkv_pkg::DATA_W-1:0] nb_key,
    input  wire [lkv_pkg::DATA_W-1:0] nb_value,
    output logic [lkv_pkg::DATA_W-1:0] key,
    output logic [lkv_pkg::DATA_W-1:0] value,
    output logic                     match
);
    import lkv_pkg::*;

    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              valid_reg;
    logic              match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg   <= new_key;
            value_reg <= new_value;
        end
        else if (ctl.shift)
        begin
            key_reg   <= nb_key;
            value_reg <= nb_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.upd)
            begin
                valid_reg <= ctl.valid;
            end
            if (capture)
            begin
                match_reg <= valid_reg && (key_reg == lookup_key);
            end
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

### src/lkv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire [63:0]                s_tdata,
    input  wire                       s_tuser,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [63:0]               m_tdata,
    output logic [1:0]                m_tuser,
    input  wire [lkv_pkg::CAP_W-1:0]  capacity,
    input  wire [ENTRIES-1:0]         match_vec,
    input  wire [lkv_pkg::DATA_W-1:0] cell_key [ENTRIES],
    input  wire [lkv_pkg::DATA_W-1:0] cell_value [ENTRIES],
    output lkv_pkg::cell_ctl_t        ctl [ENTRIES],
    output logic [lkv_pkg::DATA_W-1:0] new_key,
    output logic [lkv_pkg::DATA_W-1:0] new_value
);
    import lkv_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    state_t            state_reg, state_next;
    logic              cmd_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CW-1:0]     count_reg, count_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic              evicted_reg, evicted_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;
    logic [DATA_W-1:0] evicted_key_reg, evicted_key_next;

    logic              accept;
    logic              upd;
    logic              hit;
    logic              evict;
    logic              removing;
    logic              append;
    logic [IW-1:0]     hit_pos;
    logic [IW-1:0]     pos;
    logic [DATA_W-1:0] hit_value;
    logic [CW-1:0]     count_rm;
    logic [CW-1:0]     count_after;
    logic [XW-1:0]     cap_eff;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        hit_value = '0;
        hit_pos   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_value = hit_value | cell_value[i];
                hit_pos   = hit_pos | IW'(i);
            end
        end
    end

    always_comb
    begin
        cap_eff     = (capacity == '0) ? XW'(1) :
                      ((XW'(capacity) > XW'(ENTRIES)) ? XW'(ENTRIES) : XW'(capacity));
        hit         = |match_vec;
        evict       = !hit && (cmd_reg == CMD_PUT) && (XW'(count_reg) >= cap_eff);
        removing    = hit || evict;
        append      = hit || (cmd_reg == CMD_PUT);
        pos         = hit ? hit_pos : '0;
        count_rm    = count_reg - CW'(removing);
        count_after = count_rm + CW'(append);
        new_key     = key_reg;
        new_value   = (hit && (cmd_reg == CMD_GET)) ? hit_value : value_reg;

        upd              = 1'b0;
        state_next       = state_reg;
        s_tready         = 1'b0;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        found_next       = found_reg;
        evicted_next     = evicted_reg;
        read_value_next  = read_value_reg;
        evicted_key_next = evicted_key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    upd              = 1'b1;
                    state_next       = ST_IDLE;
                    count_next       = count_after;
                    out_valid_next   = 1'b1;
                    found_next       = hit;
                    evicted_next     = evict;
                    read_value_next  = (hit && (cmd_reg == CMD_GET)) ? hit_value : '0;
                    evicted_key_next = evict ? cell_key[0] : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        for (int i = 0; i < ENTRIES; i++)
        begin
            ctl[i].upd   = upd;
            ctl[i].load  = upd && append && (CW'(i) == count_rm);
            ctl[i].shift = upd && removing && (IW'(i) >= pos) && (CW'(i) < count_rm);
            ctl[i].valid = CW'(i) < count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
        found_reg       <= found_next;
        evicted_reg     <= evicted_next;
        read_value_reg  <= read_value_next;
        evicted_key_reg <= evicted_key_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {evicted_key_reg, read_value_reg};
    assign m_tuser  = {evicted_reg, found_reg};

endmodule

`default_nettype wire

### src/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement. Requests enter on
// the s_ stream (tuser selects get or put) and each produces exactly one response on the m_
// stream. Entries sit in a row of cells ordered by recency, least recent in cell 0; every cell
// compares its key in parallel and the row shifts by one cell on a promotion or an eviction.
// A request is compared in parallel in the cells as it is accepted; the row shift and response
// load follow in the update state, which waits while the response register is held on m_tready.
// Capacity is set over the APB port at address 0 (reset 16, 0 acts as 1, values above
// ENTRIES act as ENTRIES) and should only be written while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // key[31:0], value[63:32]
    input  wire         s_tuser,   // command
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // read_value[31:0], evicted_key[63:32]
    output logic [1:0]  m_tuser,   // found[0], evicted[1]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lkv_pkg::*;

    logic [CAP_W-1:0]  capacity_reg;
    logic [ENTRIES-1:0] match_vec;
    logic [DATA_W-1:0] cell_key [ENTRIES];
    logic [DATA_W-1:0] cell_value [ENTRIES];
    cell_ctl_t         ctl [ENTRIES];
    logic [DATA_W-1:0] new_key;
    logic [DATA_W-1:0] new_value;
    logic              capture;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign capture = s_tvalid && s_tready;

    lkv_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .capacity  (capacity_reg),
        .match_vec (match_vec),
        .cell_key  (cell_key),
        .cell_value(cell_value),
        .ctl       (ctl),
        .new_key   (new_key),
        .new_value (new_value)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [DATA_W-1:0] nb_key;
        logic [DATA_W-1:0] nb_value;

        if (i + 1 < ENTRIES)
        begin : g_nb
            assign nb_key   = cell_key[i+1];
            assign nb_value = cell_value[i+1];
        end
        else
        begin : g_end
            assign nb_key   = '0;
            assign nb_value = '0;
        end

        lkv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .capture   (capture),
            .lookup_key(s_tdata[31:0]),
            .ctl       (ctl[i]),
            .new_key   (new_key),
            .new_value (new_value),
            .nb_key    (nb_key),
            .nb_value  (nb_value),
            .key       (cell_key[i]),
            .value     (cell_value[i]),
            .match     (match_vec[i])
        );
    end

endmodule

`default_nettype wire

### src/lkv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [63:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // A stalled response holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("response changed while stalled");

    // One request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // Every request has a response pending once its update state has passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("response missing after request");

    // An eviction only happens on a miss and never returns a read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata[31:0] == 32'd0))
        else $error("eviction reported with a hit or read value");

    // A miss never carries a read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[31:0] == 32'd0))
        else $error("read value on a miss");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

`default_nettype wire
